### sv/frt_pkg.sv
// frt_pkg: sizes, codes and state encoding of the fragment reassembly table
// used by fragment_reassembly_table_top; depends on nothing else
package frt_pkg;

    localparam int ENTRIES    = 16;
    localparam int POS_W      = 4;
    localparam int USED_W     = 5;
    localparam int FRAG_WORDS = 32;
    localparam int FW_W       = 5;
    localparam int FILL_W     = 6;
    localparam int ASM_WORDS  = 64;
    localparam int ASM_W      = 6;
    localparam int PAY_DEPTH  = ENTRIES * FRAG_WORDS;
    localparam int PAY_AW     = 9;
    localparam int FRAG_BYTES = 256;
    localparam int ASM_BYTES  = ASM_WORDS * 8;

    localparam logic [1:0] CFG_QUEUE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_MAX_BYTES   = 2'd1;
    localparam logic [1:0] CFG_EXPIRY      = 2'd2;

    typedef enum logic [1:0] {
        OP_HEADER  = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_TICK    = 2'd2,
        OP_QUERY   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_WORD = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_EVICT,
        S_INS_WRITE,
        S_INS_LIMIT,
        S_PAYLOAD,
        S_TICK_AGE,
        S_TICK_SCAN,
        S_Q_HEAD,
        S_Q_SCAN,
        S_C_ENT,
        S_C_RD,
        S_C_WR,
        S_RM,
        S_O_RD,
        S_O_WR,
        S_RESP
    } fsm_t;

endpackage

### sv/fragment_reassembly_table_top.sv
// fragment_reassembly_table_top: fragment table, payload and assembly memories
// and the sequencer that inserts, ages, scans and reassembles; uses frt_pkg
//
// channel | dir | tdata (low bit up)                                  | tuser   | tlast
// s_*     | in  | frag_id 32, frag_offset 16, frag_size 9,            | opcode  | data_last
//         |     | frag_count 16, data_word 64, zero pad to 144        |         |
// m_*     | out | packet_word 64, packet_bytes 16                     | status  | last
// cfg_*   | in  | cfg_addr selects queue_limit / max_packet_bytes / expiry_ticks
//
// one beat is taken at a time; s_tready is high only while the sequencer is idle
// header: evict, write, limit check; payload word: one write; tick: age, then scan the
// entries; query: per head candidate a scan up to the completing one, a read and write
// per source word plus a flush per fragment, id removal, a read and write per packet word
// reset clears the table, the open fragment and the assembly valid bits at once
// a full result register stalls the sequencer until m_tready takes the beat
module fragment_reassembly_table_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // frag_id, frag_offset, frag_size, frag_count, data_word
    input  logic [1:0]   s_tuser,   // opcode
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // packet_word, packet_bytes
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [9:0]   cfg_wdata
);

    localparam logic [frt_pkg::USED_W-1:0] USED_FULL = frt_pkg::USED_W'(frt_pkg::ENTRIES);

    // configuration
    logic [4:0] queue_limit_reg;
    logic [9:0] max_bytes_reg;
    logic [7:0] expiry_reg;

    // latched input beat
    logic [31:0] in_id_reg;
    logic [15:0] in_off_reg;
    logic [8:0]  in_size_reg;
    logic [15:0] in_cnt_reg;
    logic [63:0] in_data_reg;
    logic        in_last_reg;

    // table kept in arrival order, one row per position
    logic [frt_pkg::POS_W-1:0] pos_slot [frt_pkg::ENTRIES];
    logic [31:0]               pos_id   [frt_pkg::ENTRIES];
    logic [15:0]               pos_off  [frt_pkg::ENTRIES];
    logic [15:0]               pos_cnt  [frt_pkg::ENTRIES];
    logic [8:0]                pos_size [frt_pkg::ENTRIES];
    logic [7:0]                pos_age  [frt_pkg::ENTRIES];
    logic [frt_pkg::FILL_W-1:0] slot_fill [frt_pkg::ENTRIES];

    logic [frt_pkg::USED_W-1:0]  used_reg;
    logic [frt_pkg::ENTRIES-1:0] slot_valid_reg;
    logic [frt_pkg::POS_W-1:0]   open_slot_reg;
    logic                        open_valid_reg;
    logic [frt_pkg::FILL_W-1:0]  fill_ptr_reg;
    logic                        evicted_reg;

    // sequencer
    frt_pkg::fsm_t state_reg, state_next;
    logic [frt_pkg::USED_W-1:0] idx_reg, h_reg, jstop_reg;
    logic [31:0] hid_reg;
    logic [15:0] hcnt_reg;
    logic [4:0]  cnt_reg;
    logic [12:0] sum_reg;
    logic        q_ok_reg;
    frt_pkg::status_t res_status_reg;

    // copy of one fragment
    logic [frt_pkg::POS_W-1:0]  t_slot_reg;
    logic [15:0]                t_off_reg;
    logic [8:0]                 t_size_reg;
    logic [frt_pkg::FILL_W-1:0] t_fill_reg;
    logic [frt_pkg::FILL_W-1:0] w_reg, nwf_reg;
    logic [6:0]                 dest_reg;
    logic                       src_ok_reg;
    logic [63:0]                carry_d_reg;
    logic [7:0]                 carry_m_reg;

    // packet output
    logic [6:0] k_reg, nw_out_reg;

    // memories
    logic [63:0] pay_mem [frt_pkg::PAY_DEPTH];
    logic [63:0] pay_rdata_reg;
    logic [63:0] asm_mem [frt_pkg::ASM_WORDS];
    logic [63:0] asm_rdata_reg;
    logic        asm_rvalid_reg;
    logic [frt_pkg::ASM_WORDS-1:0] asm_valid_reg;

    // result register
    logic             out_valid_reg;
    frt_pkg::status_t out_status_reg;
    logic [63:0]      out_word_reg;
    logic [15:0]      out_bytes_reg;
    logic             out_last_reg;

    // read port of the table
    logic [frt_pkg::POS_W-1:0] rd_pos;
    logic [frt_pkg::POS_W-1:0] rd_slot;
    logic [31:0] rd_id;
    logic [15:0] rd_off, rd_cnt;
    logic [8:0]  rd_size;
    logic [7:0]  rd_age;
    logic        idx_in, id_hit, over_bound, success, out_free;
    logic [9:0]  bound;
    logic [16:0] end_sum;
    logic [4:0]  cnt_inc;

    // control strobes
    logic                      drop_en;
    logic [frt_pkg::POS_W-1:0] drop_pos;
    logic [frt_pkg::POS_W-1:0] drop_slot;
    logic                      out_load;
    logic [frt_pkg::POS_W-1:0] free_slot;

    // copy merge
    logic [7:0]   lo_mask, merge_m;
    logic [127:0] wide_d;
    logic [15:0]  wide_m;
    logic [63:0]  src_d, merge_d, bit_m, asm_old, asm_wdata;
    logic         asm_we;
    logic [9:0]   nb;
    logic [6:0]   nw_calc;

    assign s_tready = (state_reg == frt_pkg::S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign rd_pos  = (state_reg == frt_pkg::S_Q_HEAD) ? h_reg[frt_pkg::POS_W-1:0]
                                                      : idx_reg[frt_pkg::POS_W-1:0];
    assign rd_slot = pos_slot[rd_pos];
    assign rd_id   = pos_id[rd_pos];
    assign rd_off  = pos_off[rd_pos];
    assign rd_cnt  = pos_cnt[rd_pos];
    assign rd_size = pos_size[rd_pos];
    assign rd_age  = pos_age[rd_pos];

    assign idx_in     = idx_reg < used_reg;
    assign id_hit     = rd_id == hid_reg;
    assign bound      = (max_bytes_reg > 10'(frt_pkg::ASM_BYTES)) ? 10'(frt_pkg::ASM_BYTES)
                                                                   : max_bytes_reg;
    assign end_sum    = {1'b0, rd_off} + {8'd0, rd_size};
    assign over_bound = end_sum > {7'd0, bound};
    assign cnt_inc    = cnt_reg + 5'd1;
    assign success    = {11'd0, cnt_inc} > hcnt_reg;
    assign drop_slot  = pos_slot[drop_pos];

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = frt_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
                free_slot = frt_pkg::POS_W'(i);
        end
    end

    // byte merge of one source word into the assembly word
    always_comb
    begin
        for (int b = 0; b < 8; b++)
            lo_mask[b] = ({1'b0, w_reg, 3'b000} + 10'(b)) < {1'b0, t_size_reg};
        src_d   = src_ok_reg ? pay_rdata_reg : 64'd0;
        wide_d  = {64'd0, src_d} << {t_off_reg[2:0], 3'b000};
        wide_m  = {8'd0, lo_mask} << t_off_reg[2:0];
        merge_d = wide_d[63:0] | carry_d_reg;
        merge_m = wide_m[7:0] | carry_m_reg;
        for (int b = 0; b < 8; b++)
            bit_m[b*8 +: 8] = {8{merge_m[b]}};
        asm_old   = asm_rvalid_reg ? asm_rdata_reg : 64'd0;
        asm_wdata = (asm_old & ~bit_m) | (merge_d & bit_m);
        asm_we    = (state_reg == frt_pkg::S_C_WR) && (|merge_m) && !dest_reg[6];
    end

    // packet length in words
    always_comb
    begin
        nb      = (sum_reg > 13'(frt_pkg::ASM_BYTES)) ? 10'(frt_pkg::ASM_BYTES) : sum_reg[9:0];
        nw_calc = 7'((11'(nb) + 11'd7) >> 3);
        if (nw_calc == 7'd0)
            nw_calc = 7'd1;
    end

    // next state and strobes
    always_comb
    begin
        state_next = state_reg;
        drop_en    = 1'b0;
        drop_pos   = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            frt_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (frt_pkg::opcode_t'(s_tuser))
                        frt_pkg::OP_HEADER:  state_next = frt_pkg::S_INS_EVICT;
                        frt_pkg::OP_PAYLOAD: state_next = frt_pkg::S_PAYLOAD;
                        frt_pkg::OP_TICK:    state_next = frt_pkg::S_TICK_AGE;
                        frt_pkg::OP_QUERY:   state_next = frt_pkg::S_Q_HEAD;
                        default:             state_next = frt_pkg::S_RESP;
                    endcase
                end
            end
            frt_pkg::S_INS_EVICT:
            begin
                drop_en    = (used_reg == USED_FULL);
                state_next = frt_pkg::S_INS_WRITE;
            end
            frt_pkg::S_INS_WRITE:
                state_next = frt_pkg::S_INS_LIMIT;
            frt_pkg::S_INS_LIMIT:
            begin
                drop_en    = !evicted_reg && (used_reg > queue_limit_reg);
                state_next = frt_pkg::S_RESP;
            end
            frt_pkg::S_PAYLOAD:
                state_next = frt_pkg::S_RESP;
            frt_pkg::S_TICK_AGE:
                state_next = frt_pkg::S_TICK_SCAN;
            frt_pkg::S_TICK_SCAN:
            begin
                if (idx_in)
                begin
                    drop_en  = rd_age > expiry_reg;
                    drop_pos = idx_reg[frt_pkg::POS_W-1:0];
                end
                else
                    state_next = frt_pkg::S_RESP;
            end
            frt_pkg::S_Q_HEAD:
                state_next = (h_reg < used_reg) ? frt_pkg::S_Q_SCAN : frt_pkg::S_RESP;
            frt_pkg::S_Q_SCAN:
            begin
                priority if (!idx_in)
                    state_next = frt_pkg::S_Q_HEAD;
                else if (id_hit && over_bound)
                    state_next = frt_pkg::S_RM;
                else if (id_hit && success)
                    state_next = frt_pkg::S_C_ENT;
                else
                    state_next = frt_pkg::S_Q_SCAN;
            end
            frt_pkg::S_C_ENT:
            begin
                priority if (idx_reg > jstop_reg)
                    state_next = frt_pkg::S_RM;
                else if (id_hit)
                    state_next = frt_pkg::S_C_RD;
                else
                    state_next = frt_pkg::S_C_ENT;
            end
            frt_pkg::S_C_RD:
                state_next = frt_pkg::S_C_WR;
            frt_pkg::S_C_WR:
                state_next = (w_reg == nwf_reg) ? frt_pkg::S_C_ENT : frt_pkg::S_C_RD;
            frt_pkg::S_RM:
            begin
                if (idx_in)
                begin
                    drop_en  = id_hit;
                    drop_pos = idx_reg[frt_pkg::POS_W-1:0];
                end
                else
                    state_next = q_ok_reg ? frt_pkg::S_O_RD : frt_pkg::S_RESP;
            end
            frt_pkg::S_O_RD:
                state_next = frt_pkg::S_O_WR;
            frt_pkg::S_O_WR:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = (k_reg + 7'd1 == nw_out_reg) ? frt_pkg::S_IDLE
                                                             : frt_pkg::S_O_RD;
                end
            end
            frt_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = frt_pkg::S_IDLE;
                end
            end
            default:
                state_next = frt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= frt_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg <= 5'd16;
            max_bytes_reg   <= 10'd512;
            expiry_reg      <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                frt_pkg::CFG_QUEUE_LIMIT: queue_limit_reg <= cfg_wdata[4:0];
                frt_pkg::CFG_MAX_BYTES:   max_bytes_reg   <= cfg_wdata;
                frt_pkg::CFG_EXPIRY:      expiry_reg      <= cfg_wdata[7:0];
                default:                  ;
            endcase
        end
    end

    // table control state: occupancy, slot ownership, open fragment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            slot_valid_reg <= '0;
            open_slot_reg  <= '0;
            open_valid_reg <= 1'b0;
            fill_ptr_reg   <= '0;
        end
        else if (drop_en)
        begin
            used_reg                  <= used_reg - 5'd1;
            slot_valid_reg[drop_slot] <= 1'b0;
            if (open_slot_reg == drop_slot)
                open_valid_reg <= 1'b0;
        end
        else if (state_reg == frt_pkg::S_INS_WRITE)
        begin
            used_reg                  <= used_reg + 5'd1;
            slot_valid_reg[free_slot] <= 1'b1;
            open_slot_reg             <= free_slot;
            open_valid_reg            <= 1'b1;
            fill_ptr_reg              <= '0;
        end
        else if (state_reg == frt_pkg::S_PAYLOAD && open_valid_reg)
        begin
            if (fill_ptr_reg < frt_pkg::FILL_W'(frt_pkg::FRAG_WORDS))
                fill_ptr_reg <= fill_ptr_reg + 6'd1;
            if (in_last_reg)
                open_valid_reg <= 1'b0;
        end
    end

    // table rows: compaction on drop, append on insert, aging on tick
    always_ff @(posedge clk)
    begin
        if (drop_en)
        begin
            for (int p = 0; p < frt_pkg::ENTRIES - 1; p++)
            begin
                if (frt_pkg::POS_W'(p) >= drop_pos)
                begin
                    pos_slot[p] <= pos_slot[p+1];
                    pos_id[p]   <= pos_id[p+1];
                    pos_off[p]  <= pos_off[p+1];
                    pos_cnt[p]  <= pos_cnt[p+1];
                    pos_size[p] <= pos_size[p+1];
                    pos_age[p]  <= pos_age[p+1];
                end
            end
            pos_slot[frt_pkg::ENTRIES-1] <= drop_slot;
        end
        else if (state_reg == frt_pkg::S_INS_WRITE)
        begin
            pos_slot[used_reg[frt_pkg::POS_W-1:0]] <= free_slot;
            pos_id[used_reg[frt_pkg::POS_W-1:0]]   <= in_id_reg;
            pos_off[used_reg[frt_pkg::POS_W-1:0]]  <= in_off_reg;
            pos_cnt[used_reg[frt_pkg::POS_W-1:0]]  <= in_cnt_reg;
            pos_size[used_reg[frt_pkg::POS_W-1:0]] <= in_size_reg;
            pos_age[used_reg[frt_pkg::POS_W-1:0]]  <= 8'd0;
        end
        else if (state_reg == frt_pkg::S_TICK_AGE)
        begin
            for (int p = 0; p < frt_pkg::ENTRIES; p++)
            begin
                if (pos_age[p] != 8'hFF)
                    pos_age[p] <= pos_age[p] + 8'd1;
            end
        end

        // words written per slot; later words read as zero
        if (state_reg == frt_pkg::S_INS_WRITE)
            slot_fill[free_slot] <= '0;
        else if (state_reg == frt_pkg::S_PAYLOAD && open_valid_reg
                 && fill_ptr_reg < frt_pkg::FILL_W'(frt_pkg::FRAG_WORDS))
            slot_fill[open_slot_reg] <= fill_ptr_reg + 6'd1;
    end

    // sequencer datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            frt_pkg::S_IDLE:
            begin
                in_id_reg   <= s_tdata[31:0];
                in_off_reg  <= s_tdata[47:32];
                in_size_reg <= (s_tdata[56:48] > 9'(frt_pkg::FRAG_BYTES))
                               ? 9'(frt_pkg::FRAG_BYTES) : s_tdata[56:48];
                in_cnt_reg  <= s_tdata[72:57];
                in_data_reg <= s_tdata[136:73];
                in_last_reg <= s_tlast;
                h_reg          <= '0;
                idx_reg        <= '0;
                res_status_reg <= frt_pkg::ST_NONE;
                q_ok_reg       <= 1'b0;
            end
            frt_pkg::S_INS_EVICT:
                evicted_reg <= (used_reg == USED_FULL);
            frt_pkg::S_TICK_SCAN:
            begin
                if (idx_in && !drop_en)
                    idx_reg <= idx_reg + 5'd1;
            end
            frt_pkg::S_Q_HEAD:
            begin
                hid_reg  <= rd_id;
                hcnt_reg <= rd_cnt;
                cnt_reg  <= '0;
                sum_reg  <= '0;
                idx_reg  <= '0;
            end
            frt_pkg::S_Q_SCAN:
            begin
                priority if (!idx_in)
                    h_reg <= h_reg + 5'd1;
                else if (id_hit && over_bound)
                begin
                    res_status_reg <= frt_pkg::ST_FAIL;
                    idx_reg        <= '0;
                end
                else if (id_hit)
                begin
                    cnt_reg <= cnt_inc;
                    sum_reg <= sum_reg + {4'd0, rd_size};
                    if (success)
                    begin
                        q_ok_reg  <= 1'b1;
                        jstop_reg <= idx_reg;
                        idx_reg   <= '0;
                    end
                    else
                        idx_reg <= idx_reg + 5'd1;
                end
                else
                    idx_reg <= idx_reg + 5'd1;
            end
            frt_pkg::S_C_ENT:
            begin
                priority if (idx_reg > jstop_reg)
                    idx_reg <= '0;
                else if (id_hit)
                begin
                    t_slot_reg  <= rd_slot;
                    t_off_reg   <= rd_off;
                    t_size_reg  <= rd_size;
                    t_fill_reg  <= slot_fill[rd_slot];
                    w_reg       <= '0;
                    nwf_reg     <= 6'(({1'b0, rd_size} + 10'd7) >> 3);
                    carry_d_reg <= '0;
                    carry_m_reg <= '0;
                end
                else
                    idx_reg <= idx_reg + 5'd1;
            end
            frt_pkg::S_C_RD:
            begin
                src_ok_reg <= w_reg < t_fill_reg;
                dest_reg   <= t_off_reg[9:3] + {1'b0, w_reg};
            end
            frt_pkg::S_C_WR:
            begin
                carry_d_reg <= wide_d[127:64];
                carry_m_reg <= wide_m[15:8];
                w_reg       <= w_reg + 6'd1;
                if (w_reg == nwf_reg)
                    idx_reg <= idx_reg + 5'd1;
            end
            frt_pkg::S_RM:
            begin
                if (idx_in && !id_hit)
                    idx_reg <= idx_reg + 5'd1;
                k_reg      <= '0;
                nw_out_reg <= nw_calc;
            end
            frt_pkg::S_O_WR:
            begin
                if (out_free)
                    k_reg <= k_reg + 7'd1;
            end
            default:
                ;
        endcase
    end

    // payload memory: written by payload beats, read during the copy
    always_ff @(posedge clk)
    begin
        if (state_reg == frt_pkg::S_PAYLOAD && open_valid_reg
            && fill_ptr_reg < frt_pkg::FILL_W'(frt_pkg::FRAG_WORDS))
            pay_mem[{open_slot_reg, fill_ptr_reg[frt_pkg::FW_W-1:0]}] <= in_data_reg;
        if (state_reg == frt_pkg::S_C_RD)
            pay_rdata_reg <= pay_mem[{t_slot_reg, w_reg[frt_pkg::FW_W-1:0]}];
    end

    // assembly memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (asm_we)
            asm_mem[dest_reg[frt_pkg::ASM_W-1:0]] <= asm_wdata;
        if (state_reg == frt_pkg::S_C_RD)
            asm_rdata_reg <= asm_mem[t_off_reg[8:3] + w_reg];
        else if (state_reg == frt_pkg::S_O_RD)
            asm_rdata_reg <= asm_mem[k_reg[frt_pkg::ASM_W-1:0]];
    end

    // assembly words never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_valid_reg  <= '0;
            asm_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (asm_we)
                asm_valid_reg[dest_reg[frt_pkg::ASM_W-1:0]] <= 1'b1;
            if (state_reg == frt_pkg::S_C_RD)
                asm_rvalid_reg <= asm_valid_reg[t_off_reg[8:3] + w_reg]
                                  && ((t_off_reg[9:3] + {1'b0, w_reg}) < 7'd64);
            else if (state_reg == frt_pkg::S_O_RD)
                asm_rvalid_reg <= asm_valid_reg[k_reg[frt_pkg::ASM_W-1:0]];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (state_reg == frt_pkg::S_O_WR)
            begin
                out_status_reg <= frt_pkg::ST_WORD;
                out_word_reg   <= asm_rvalid_reg ? asm_rdata_reg : 64'd0;
                out_bytes_reg  <= {3'd0, sum_reg};
                out_last_reg   <= (k_reg + 7'd1 == nw_out_reg);
            end
            else
            begin
                out_status_reg <= res_status_reg;
                out_word_reg   <= '0;
                out_bytes_reg  <= '0;
                out_last_reg   <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bytes_reg, out_word_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_FULL)
        else $error("table occupancy above capacity");
    a_used_slots: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == 32'(used_reg))
        else $error("slot ownership and occupancy disagree");
    a_open_slot: assert property (@(posedge clk) disable iff (!rst_n)
        open_valid_reg |-> slot_valid_reg[open_slot_reg])
        else $error("open fragment points at a free slot");
    a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != frt_pkg::ST_WORD) |-> (m_tlast && m_tdata == 80'd0))
        else $error("non-word result carries data or misses last");
`endif

endmodule
